// ----- design/sfia_pkg.sv -----
// ----------------------------------------------------------------------------
// sfia_pkg
// Shared types and constants for the strided flat index to address block.
// ----------------------------------------------------------------------------
package sfia_pkg;

    localparam int MAX_DIMS = 4;
    localparam int DIM_REGS = 4;
    localparam int DIM_IW   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int IDX_W    = 32;
    localparam int OFF_W    = 48;
    localparam int BYTE_W   = 51;
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;
    // One pass per dimension: 32 division steps and one closing cell.
    localparam int PASS_LEN = IDX_W + 1;
    localparam int CHAIN_LEN = MAX_DIMS * PASS_LEN;

    localparam logic [2:0] REG_BASE  = 3'd0;
    localparam logic [2:0] REG_NDIMS = 3'd1;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_BYTES = 3'd3;
    localparam logic [2:0] REG_DIM0  = 3'd4;
    localparam logic [2:0] REG_DIM1  = 3'd5;
    localparam logic [2:0] REG_DIM2  = 3'd6;
    localparam logic [2:0] REG_DIM3  = 3'd7;

    typedef struct packed {
        logic [31:0]                 base;
        logic [2:0]                  num_dims;
        logic [31:0]                 count;
        logic [3:0]                  bytes;
        logic [MAX_DIMS-1:0][31:0]   size;
        logic [MAX_DIMS-1:0][31:0]   stride;
    } t_cfg;

    typedef struct packed {
        logic                          valid;
        logic                          in_range;
        logic [IDX_W-1:0]              rest;
        logic [IDX_W-1:0]              work;
        logic [IDX_W-1:0]              rem;
        logic [IDX_W-1:0]              quo;
        logic [MAX_DIMS-1:0][IDX_W-1:0] digit;
    } t_cell;

endpackage

// ----- design/strided_flat_index_to_address.sv -----
// Throughput: one beat per cycle when not stalled; each dimension is a chain
// of 32 division cells plus a closing cell, and every beat moves one cell per
// cycle. The whole chain holds still while the output beat is stalled.
// Reset is synchronous and active low: it empties the chain and loads the
// register reset values; no clearing pass is needed.
// ----------------------------------------------------------------------------
// strided_flat_index_to_address
// Maps a flat row-major index of a strided view to element offset and
// byte address.
// ----------------------------------------------------------------------------
module strided_flat_index_to_address (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfia_pkg::ADDR_W-1:0]  paddr,
    input  logic [sfia_pkg::DATA_W-1:0]  pwdata,
    output logic [sfia_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [sfia_pkg::IDX_W-1:0]   i_flat_index,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [sfia_pkg::OFF_W-1:0]   o_element_offset,
    output logic [sfia_pkg::BYTE_W-1:0]  o_byte_address,
    output logic                         o_in_range
);
    import sfia_pkg::*;

    t_cfg                          cfg;
    t_cell                         chain [CHAIN_LEN+1];
    logic                          adv;
    logic [3:0]                    dims;
    logic [MAX_DIMS-1:0]           pass_active;
    logic [MAX_DIMS-1:0][DIM_IW-1:0] pass_dim;
    logic [MAX_DIMS-1:0][31:0]     pass_size;
    logic [MAX_DIMS-1:0][3:0]      pass_sel;

    sfia_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    assign dims = ({1'b0, cfg.num_dims} > 4'(MAX_DIMS)) ? 4'(MAX_DIMS)
                                                        : {1'b0, cfg.num_dims};

    // Pass p handles the p-th dimension counted from the innermost in use.
    always_comb begin
        for (int p = 0; p < MAX_DIMS; p++) begin
            pass_active[p] = 4'(p) < dims;
            pass_sel[p]    = dims - 4'(p + 1);
            pass_dim[p]    = pass_sel[p][DIM_IW-1:0];
            pass_size[p]   = cfg.size[pass_dim[p]];
        end
    end

    always_comb begin
        chain[0].valid    = i_valid;
        chain[0].in_range = i_flat_index < cfg.count;
        chain[0].rest     = i_flat_index;
        chain[0].work     = i_flat_index;
        chain[0].rem      = '0;
        chain[0].quo      = '0;
        chain[0].digit    = '0;
    end

    for (genvar p = 0; p < MAX_DIMS; p++) begin : g_pass
        for (genvar b = 0; b < IDX_W; b++) begin : g_bit
            sfia_div_cell u_div (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (adv),
                .i_size  (pass_size[p]),
                .i_cell  (chain[p*PASS_LEN + b]),
                .o_cell  (chain[p*PASS_LEN + b + 1])
            );
        end
        sfia_pass_cell u_pass (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_active (pass_active[p]),
            .i_dim    (pass_dim[p]),
            .i_size   (pass_size[p]),
            .i_cell   (chain[p*PASS_LEN + IDX_W]),
            .o_cell   (chain[p*PASS_LEN + IDX_W + 1])
        );
    end

    sfia_sum u_sum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_cfg      (cfg),
        .i_cell     (chain[CHAIN_LEN]),
        .o_valid    (o_valid),
        .o_offset   (o_element_offset),
        .o_byte     (o_byte_address),
        .o_in_range (o_in_range)
    );

endmodule

// ----- design/sfia_cfg.sv -----
// ----------------------------------------------------------------------------
// sfia_cfg
// APB register file holding the view description.
// ----------------------------------------------------------------------------
module sfia_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [sfia_pkg::ADDR_W-1:0]  paddr,
    input  logic [sfia_pkg::DATA_W-1:0]  pwdata,
    output logic [sfia_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output sfia_pkg::t_cfg               o_cfg
);
    import sfia_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr     = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base     <= '0;
            r_cfg.num_dims <= '0;
            r_cfg.count    <= 32'd1;
            r_cfg.bytes    <= 4'd4;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_cfg.size[d]   <= 32'd1;
                r_cfg.stride[d] <= 32'd1;
            end
        end else if (wr) begin
            case (idx)
                REG_BASE:  r_cfg.base     <= pwdata[31:0];
                REG_NDIMS: r_cfg.num_dims <= pwdata[2:0];
                REG_COUNT: r_cfg.count    <= pwdata[31:0];
                REG_BYTES: r_cfg.bytes    <= pwdata[3:0];
                default: begin
                    for (int d = 0; d < MAX_DIMS; d++) begin
                        if (d < DIM_REGS && idx == 3'(REG_DIM0 + 3'(d))) begin
                            r_cfg.size[d]   <= pwdata[63:32];
                            r_cfg.stride[d] <= pwdata[31:0];
                        end
                    end
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_BASE:  prdata = {32'd0, r_cfg.base};
            REG_NDIMS: prdata = {61'd0, r_cfg.num_dims};
            REG_COUNT: prdata = {32'd0, r_cfg.count};
            REG_BYTES: prdata = {60'd0, r_cfg.bytes};
            default: begin
                for (int d = 0; d < MAX_DIMS; d++) begin
                    if (d < DIM_REGS && idx == 3'(REG_DIM0 + 3'(d))) begin
                        prdata = {r_cfg.size[d], r_cfg.stride[d]};
                    end
                end
            end
        endcase
    end

endmodule

// ----- design/sfia_div_cell.sv -----
// ----------------------------------------------------------------------------
// sfia_div_cell
// One restoring division step: brings in one dividend bit, yields one
// quotient bit.
// ----------------------------------------------------------------------------
module sfia_div_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  logic [31:0]     i_size,
    input  sfia_pkg::t_cell i_cell,
    output sfia_pkg::t_cell o_cell
);
    import sfia_pkg::*;

    logic        r_valid;
    t_cell       r_data;
    t_cell       n_data;
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;

    always_comb begin
        trial  = {i_cell.rem, i_cell.work[IDX_W-1]};
        diff   = trial - {1'b0, i_size};
        ge     = trial >= {1'b0, i_size};
        n_data = i_cell;
        // When the trial is below the size it fits in 32 bits.
        n_data.rem  = ge ? diff[31:0] : trial[31:0];
        n_data.work = {i_cell.work[IDX_W-2:0], 1'b0};
        n_data.quo  = {i_cell.quo[IDX_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_cell       = r_data;
        o_cell.valid = r_valid;
    end

endmodule

// ----- design/sfia_pass_cell.sv -----
// ----------------------------------------------------------------------------
// sfia_pass_cell
// Closes one dimension: stores its digit and restarts the division on the
// quotient for the next dimension outward.
// ----------------------------------------------------------------------------
module sfia_pass_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_active,
    input  logic [sfia_pkg::DIM_IW-1:0] i_dim,
    input  logic [31:0]                 i_size,
    input  sfia_pkg::t_cell             i_cell,
    output sfia_pkg::t_cell             o_cell
);
    import sfia_pkg::*;

    logic             r_valid;
    t_cell            r_data;
    t_cell            n_data;
    logic [IDX_W-1:0] next_rest;

    always_comb begin
        n_data    = i_cell;
        next_rest = i_cell.rest;
        if (i_active) begin
            // A zero size takes the whole remaining index as its digit.
            if (i_size == '0) begin
                n_data.digit[i_dim] = i_cell.rest;
                next_rest           = '0;
            end else begin
                n_data.digit[i_dim] = i_cell.rem;
                next_rest           = i_cell.quo;
            end
        end
        n_data.rest = next_rest;
        n_data.work = next_rest;
        n_data.rem  = '0;
        n_data.quo  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    always_comb begin
        o_cell       = r_data;
        o_cell.valid = r_valid;
    end

endmodule

// ----- design/sfia_sum.sv -----
// ----------------------------------------------------------------------------
// sfia_sum
// Multiplies digits by strides, accumulates onto the base offset one
// dimension per stage, and scales the result to a byte address.
// ----------------------------------------------------------------------------
module sfia_sum (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  sfia_pkg::t_cfg              i_cfg,
    input  sfia_pkg::t_cell             i_cell,
    output logic                        o_valid,
    output logic [sfia_pkg::OFF_W-1:0]  o_offset,
    output logic [sfia_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_in_range
);
    import sfia_pkg::*;

    logic [MAX_DIMS:0]                           r_v;
    logic [MAX_DIMS:0]                           r_inr;
    logic [MAX_DIMS:0][OFF_W-1:0]                r_acc;
    logic [MAX_DIMS:0][MAX_DIMS-1:0][OFF_W-1:0]  r_prod;
    logic                                        r_out_v;
    logic [OFF_W-1:0]                            r_off;
    logic [BYTE_W-1:0]                           r_byte;
    logic                                        r_out_inr;
    logic [OFF_W+3:0]                            scaled;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else if (i_adv) begin
            r_v     <= {r_v[MAX_DIMS-1:0], i_cell.valid};
            r_out_v <= r_v[MAX_DIMS];
        end
    end

    // Stage 0 forms every product; stage k+1 adds product k.
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_inr[0] <= i_cell.in_range;
            r_acc[0] <= OFF_W'(i_cfg.base);
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_prod[0][d] <= OFF_W'(64'(i_cell.digit[d]) * 64'(i_cfg.stride[d]));
            end
            for (int k = 0; k < MAX_DIMS; k++) begin
                r_inr[k+1]  <= r_inr[k];
                r_acc[k+1]  <= r_acc[k] + r_prod[k][k];
                r_prod[k+1] <= r_prod[k];
            end
        end
    end

    assign scaled = r_acc[MAX_DIMS] * 4'(i_cfg.bytes);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_out_inr <= r_inr[MAX_DIMS];
            r_off     <= r_inr[MAX_DIMS] ? r_acc[MAX_DIMS] : '0;
            r_byte    <= r_inr[MAX_DIMS] ? scaled[BYTE_W-1:0] : '0;
        end
    end

    assign o_valid    = r_out_v;
    assign o_offset   = r_off;
    assign o_byte     = r_byte;
    assign o_in_range = r_out_inr;

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives flat indices through the strided address generator under several
// view settings written over the register port, predicts offset, byte address
// and range flag for every accepted beat, and checks each output beat in order.
// ----------------------------------------------------------------------------
class address_scoreboard;
    logic [31:0] base;
    logic [2:0]  ndims;
    logic [31:0] count;
    logic [3:0]  ebytes;
    logic [31:0] size [4];
    logic [31:0] stride [4];
    logic [47:0] exp_off [$];
    logic [50:0] exp_addr [$];
    logic        exp_rng [$];
    int          errors;

    function void reset_view();
        base = 0; ndims = 0; count = 1; ebytes = 4; errors = 0;
        for (int d = 0; d < 4; d++) begin
            size[d] = 1;
            stride[d] = 1;
        end
    endfunction

    function void note_index(logic [31:0] idx);
        logic [63:0] rest;
        logic [63:0] offs;
        logic [63:0] digit;
        int          dims;
        rest = {32'd0, idx};
        offs = {32'd0, base};
        dims = (ndims > 4) ? 4 : ndims;
        if (idx >= count) begin
            exp_off.push_back('0);
            exp_addr.push_back('0);
            exp_rng.push_back(1'b0);
            return;
        end
        for (int d = dims - 1; d >= 0; d--) begin
            if (size[d] == 0) begin
                digit = rest;
                rest = 0;
            end else begin
                digit = rest % size[d];
                rest = rest / size[d];
            end
            offs = offs + digit * stride[d];
        end
        exp_off.push_back(offs[47:0]);
        exp_addr.push_back(51'(offs[47:0] * ebytes));
        exp_rng.push_back(1'b1);
    endfunction

    function void check_beat(logic [47:0] off, logic [50:0] addr, logic rng);
        if (exp_rng.size() == 0) begin
            $error("output beat with nothing expected");
            errors++;
            return;
        end
        if (off !== exp_off[0]) begin
            $error("element_offset expected %h actual %h", exp_off[0], off);
            errors++;
        end
        if (addr !== exp_addr[0]) begin
            $error("byte_address expected %h actual %h", exp_addr[0], addr);
            errors++;
        end
        if (rng !== exp_rng[0]) begin
            $error("in_range expected %b actual %b", exp_rng[0], rng);
            errors++;
        end
        void'(exp_off.pop_front());
        void'(exp_addr.pop_front());
        void'(exp_rng.pop_front());
    endfunction

    function int pending();
        return exp_rng.size();
    endfunction
endclass

module testbench;
    import sfia_pkg::*;

    localparam int LATENCY = 33 * MAX_DIMS + MAX_DIMS + 2;
    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [DATA_W-1:0]    pwdata = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [IDX_W-1:0]     i_flat_index = '0;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [OFF_W-1:0]     o_element_offset;
    logic [BYTE_W-1:0]    o_byte_address;
    logic                 o_in_range;

    address_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int cycles;

    strided_flat_index_to_address u_dut (.*);

    always #2 i_clk = ~i_clk;

    // Output side: check on the rising edge, pick the next stall on the falling.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_beat(o_element_offset, o_byte_address, o_in_range);
    end

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_W'({idx, 3'b000});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_BASE:  sb.base = value[31:0];
            REG_NDIMS: sb.ndims = value[2:0];
            REG_COUNT: sb.count = value[31:0];
            REG_BYTES: sb.ebytes = value[3:0];
            default: begin
                sb.size[idx - REG_DIM0] = value[63:32];
                sb.stride[idx - REG_DIM0] = value[31:0];
            end
        endcase
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // Sends one beat; the valid stays high into the next beat when no idle falls.
    task automatic send_index(logic [31:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_flat_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_index(idx);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_index(logic [31:0] cnt);
        case ($urandom_range(9))
            0: return $urandom();
            1: return cnt;
            2: return cnt - 1;
            3: return 32'hFFFF_FFFF;
            4: return 0;
            default: return (cnt == 0) ? $urandom() : $urandom_range(cnt - 1);
        endcase
    endfunction

    task automatic random_view(bit extreme);
        logic [31:0] total;
        logic [31:0] sz;
        int nd;
        nd = $urandom_range(7);
        total = 1;
        write_reg(REG_NDIMS, 64'(nd));
        write_reg(REG_BASE, extreme ? 64'hFFFF_FFFF : 64'($urandom()));
        write_reg(REG_BYTES, 64'(extreme ? 15 : $urandom_range(15)));
        for (int d = 0; d < 4; d++) begin
            case ($urandom_range(5))
                0: sz = 0;
                1: sz = $urandom();
                default: sz = $urandom_range(1, 9);
            endcase
            if (d < nd) total = total * ((sz == 0) ? 32'd7 : sz);
            write_reg(REG_DIM0 + 3'(d), {sz, extreme ? 32'hFFFF_FFFF : 32'($urandom())});
        end
        write_reg(REG_COUNT, ($urandom_range(3) == 0) ? 64'($urandom()) : 64'(total));
    endtask

    initial begin
        sb = new();
        sb.reset_view();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycles = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset view: scalar with one element.
        send_index(0);
        send_index(1);
        send_index(32'hFFFF_FFFF);
        drain();

        // Four dimensions with a zero size outermost and wide strides.
        write_reg(REG_NDIMS, 64'd4);
        write_reg(REG_BASE, 64'hFFFF_FFFF);
        write_reg(REG_COUNT, 64'hFFFF_FFFF);
        write_reg(REG_BYTES, 64'd15);
        write_reg(REG_DIM0, {32'd0, 32'hFFFF_FFFF});
        write_reg(REG_DIM1, 64'h0000_0003_FFFF_FFFF);
        write_reg(REG_DIM2, 64'h0000_0005_8000_0000);
        write_reg(REG_DIM3, 64'h0000_0007_0000_0001);
        for (int b = 0; b < 32; b++) send_index(32'h1 << b);
        send_index(32'hFFFF_FFFE);
        send_index(32'hFFFF_FFFF);
        send_index(32'h5555_5555);
        send_index(32'hAAAA_AAAA);
        drain();

        // Too many dimensions, zero element size, empty view.
        write_reg(REG_NDIMS, 64'd7);
        write_reg(REG_BYTES, 64'd0);
        send_index(32'd123);
        drain();
        write_reg(REG_COUNT, 64'd0);
        send_index(32'd0);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct  = (phase == 0) ? 6 : (phase == 1) ? 76 : 0;
            recv_stall_pct = (phase == 0) ? 76 : (phase == 1) ? 6 : 0;
            for (int v = 0; v < 8; v++) begin
                random_view(v == 0);
                for (int n = 0; n < 70; n++) begin
                    if (n == 35 && v == 3) begin
                        // Hold the sender until everything in flight is out.
                        i_valid <= 1'b0;
                        while (sb.pending() != 0) @(negedge i_clk);
                    end
                    send_index(pick_index(sb.count));
                end
                drain();
            end
        end

        recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
design/sfia_pkg.sv
design/sfia_cfg.sv
design/sfia_div_cell.sv
design/sfia_pass_cell.sv
design/sfia_sum.sv
design/strided_flat_index_to_address.sv
bench/testbench.sv
